### hdl/cap_pkg.sv
// ----------------------------------------------------------------------------
// cap_pkg - shared types for the circle/box push-out core
// Field widths and the side-band record that travels down the pipeline.
// ----------------------------------------------------------------------------
package cap_pkg;

    localparam int unsigned CoordW = 32;   // signed Q16.16 coordinate
    localparam int unsigned RadW   = 31;   // unsigned Q15.16 radius
    localparam int unsigned SqW    = 2 * RadW;

    typedef logic signed [CoordW-1:0] t_coord;
    typedef logic        [RadW-1:0]   t_mag;

    // side-band that rides with each item
    typedef struct packed {
        logic   hit;
        logic   sx;     // sign of dx
        logic   sy;     // sign of dy
        t_coord nx;
        t_coord ny;
        t_mag   ax;     // |dx|, valid when not far
        t_mag   ay;
        t_mag   rad;
        t_mag   d;      // floor sqrt of squared distance
    } t_meta;

endpackage

### hdl/circle_aabb_pushout_core.sv
// ----------------------------------------------------------------------------
// circle_aabb_pushout_core - circle against axis-aligned box, Q16.16
// Clamps the centre to the box, squares the distance, takes its integer
// square root and scales the offset into a push-out vector.
//
//  channel | handshake          | payload
//  --------+--------------------+-----------------------------------------
//  input   | start, busy        | i_center_*, i_radius, i_box_min/max_*
//  result  | o_valid (strobe)   | o_hit, o_push_x/y, o_near_x/y
//
//  One item per cycle; results leave in the order the items came in.
//  The square root and the divider are 31-step pipes.
//  busy is always low: nothing in the pipe ever waits.
//  Synchronous active-low reset clears only the valid bits.
// ----------------------------------------------------------------------------
module circle_aabb_pushout_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  cap_pkg::t_coord       i_center_x,
    input  cap_pkg::t_coord       i_center_y,
    input  cap_pkg::t_mag         i_radius,
    input  cap_pkg::t_coord       i_box_min_x,
    input  cap_pkg::t_coord       i_box_min_y,
    input  cap_pkg::t_coord       i_box_max_x,
    input  cap_pkg::t_coord       i_box_max_y,
    output logic                  o_valid,
    output logic                  o_hit,
    output cap_pkg::t_coord       o_push_x,
    output cap_pkg::t_coord       o_push_y,
    output cap_pkg::t_coord       o_near_x,
    output cap_pkg::t_coord       o_near_y
);
    import cap_pkg::*;

    localparam int unsigned Steps = RadW;   // root bits and quotient bits

    assign busy = 1'b0;

    // ---------------- stage 1: clamp and offset ----------------
    logic                 r_v1;
    t_coord               r_nx1, r_ny1;
    logic signed [32:0]   r_dx1, r_dy1;
    t_mag                 r_rad1;
    t_coord               n_nx1, n_ny1;

    always_comb begin
        if (i_center_x < i_box_min_x)      n_nx1 = i_box_min_x;
        else if (i_center_x > i_box_max_x) n_nx1 = i_box_max_x;
        else                               n_nx1 = i_center_x;
        if (i_center_y < i_box_min_y)      n_ny1 = i_box_min_y;
        else if (i_center_y > i_box_max_y) n_ny1 = i_box_max_y;
        else                               n_ny1 = i_center_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else          r_v1 <= start;
        r_nx1  <= n_nx1;
        r_ny1  <= n_ny1;
        r_dx1  <= {i_center_x[31], i_center_x} - {n_nx1[31], n_nx1};
        r_dy1  <= {i_center_y[31], i_center_y} - {n_ny1[31], n_ny1};
        r_rad1 <= i_radius;
    end

    // ---------------- stage 2: magnitudes, far test ----------------
    logic        r_v2, r_far2;
    t_meta       r_m2;
    logic [32:0] n_ax2, n_ay2;

    assign n_ax2 = r_dx1[32] ? 33'(-r_dx1) : 33'(r_dx1);
    assign n_ay2 = r_dy1[32] ? 33'(-r_dy1) : 33'(r_dy1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else          r_v2 <= r_v1;
        r_far2   <= (n_ax2 >= {2'b00, r_rad1}) || (n_ay2 >= {2'b00, r_rad1});
        r_m2.hit <= 1'b0;
        r_m2.sx  <= r_dx1[32];
        r_m2.sy  <= r_dy1[32];
        r_m2.nx  <= r_nx1;
        r_m2.ny  <= r_ny1;
        r_m2.ax  <= n_ax2[RadW-1:0];
        r_m2.ay  <= n_ay2[RadW-1:0];
        r_m2.rad <= r_rad1;
        r_m2.d   <= '0;
    end

    // ---------------- stage 3: squares ----------------
    logic          r_v3, r_far3;
    t_meta         r_m3;
    logic [SqW-1:0] r_xx3, r_yy3, r_rr3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else          r_v3 <= r_v2;
        r_far3 <= r_far2;
        r_m3   <= r_m2;
        r_xx3  <= SqW'(r_m2.ax) * SqW'(r_m2.ax);
        r_yy3  <= SqW'(r_m2.ay) * SqW'(r_m2.ay);
        r_rr3  <= SqW'(r_m2.rad) * SqW'(r_m2.rad);
    end

    // ---------------- stage 4: sum and hit ----------------
    logic           r_v4;
    t_meta          r_m4;
    logic [SqW-1:0] r_dsq4;
    logic [SqW:0]   n_dsq4;
    t_meta          n_m4;

    assign n_dsq4 = {1'b0, r_xx3} + {1'b0, r_yy3};

    // side-band with the hit flag filled in
    always_comb begin
        n_m4     = r_m3;
        n_m4.hit = !r_far3 && (n_dsq4 < {1'b0, r_rr3});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v4 <= 1'b0;
        else          r_v4 <= r_v3;
        r_m4   <= n_m4;
        r_dsq4 <= n_dsq4[SqW-1:0];
    end

    // ---------------- square root: one root bit per stage ----------------
    logic              r_sv   [0:Steps];
    t_meta             r_sm   [0:Steps];
    logic [SqW-1:0]    r_sval [0:Steps];
    logic [RadW+1:0]   r_srem [0:Steps];
    logic [RadW-1:0]   r_sroot[0:Steps];

    always_comb begin
        r_sv[0]    = r_v4;
        r_sm[0]    = r_m4;
        r_sval[0]  = r_dsq4;
        r_srem[0]  = '0;
        r_sroot[0] = '0;
    end

    for (genvar k = 0; k < Steps; k++) begin : g_sqrt
        logic [RadW+3:0] n_rem, n_trial;
        assign n_rem   = {r_srem[k], r_sval[k][SqW-1-2*k -: 2]};
        assign n_trial = {2'b00, r_sroot[k], 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_sv[k+1] <= 1'b0;
            else          r_sv[k+1] <= r_sv[k];
            r_sm[k+1]   <= r_sm[k];
            r_sval[k+1] <= r_sval[k];
            if (n_rem >= n_trial) begin
                r_srem[k+1]  <= (RadW+2)'(n_rem - n_trial);
                r_sroot[k+1] <= {r_sroot[k][RadW-2:0], 1'b1};
            end else begin
                r_srem[k+1]  <= n_rem[RadW+1:0];
                r_sroot[k+1] <= {r_sroot[k][RadW-2:0], 1'b0};
            end
        end
    end

    // ---------------- gap = radius - d ----------------
    logic  r_vg;
    t_meta r_mg;
    t_mag  r_gap;
    t_meta n_mg;

    // side-band with the root filled in
    always_comb begin
        n_mg   = r_sm[Steps];
        n_mg.d = r_sroot[Steps];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vg <= 1'b0;
        else          r_vg <= r_sv[Steps];
        r_mg  <= n_mg;
        r_gap <= r_sm[Steps].rad - r_sroot[Steps];
    end

    // ---------------- scale products ----------------
    logic           r_vp;
    t_meta          r_mp;
    logic [SqW-1:0] r_px, r_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vp <= 1'b0;
        else          r_vp <= r_vg;
        r_mp <= r_mg;
        r_px <= SqW'(r_mg.ax) * SqW'(r_gap);
        r_py <= SqW'(r_mg.ay) * SqW'(r_gap);
    end

    // ---------------- divider: one quotient bit per stage ----------------
    logic           r_dv  [0:Steps];
    t_meta          r_dm  [0:Steps];
    logic [SqW-1:0] r_dnx [0:Steps];
    logic [SqW-1:0] r_dny [0:Steps];
    t_mag           r_drx [0:Steps];
    t_mag           r_dry [0:Steps];
    t_mag           r_dqx [0:Steps];
    t_mag           r_dqy [0:Steps];

    always_comb begin
        r_dv[0]  = r_vp;
        r_dm[0]  = r_mp;
        r_dnx[0] = r_px;
        r_dny[0] = r_py;
        r_drx[0] = r_px[SqW-1:RadW];
        r_dry[0] = r_py[SqW-1:RadW];
        r_dqx[0] = '0;
        r_dqy[0] = '0;
    end

    for (genvar k = 0; k < Steps; k++) begin : g_div
        logic [RadW:0] n_tx, n_ty, n_dd;
        assign n_tx = {r_drx[k], r_dnx[k][RadW-1-k]};
        assign n_ty = {r_dry[k], r_dny[k][RadW-1-k]};
        assign n_dd = {1'b0, r_dm[k].d};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_dv[k+1] <= 1'b0;
            else          r_dv[k+1] <= r_dv[k];
            r_dm[k+1]  <= r_dm[k];
            r_dnx[k+1] <= r_dnx[k];
            r_dny[k+1] <= r_dny[k];
            if (n_tx >= n_dd) begin
                r_drx[k+1] <= RadW'(n_tx - n_dd);
                r_dqx[k+1] <= {r_dqx[k][RadW-2:0], 1'b1};
            end else begin
                r_drx[k+1] <= n_tx[RadW-1:0];
                r_dqx[k+1] <= {r_dqx[k][RadW-2:0], 1'b0};
            end
            if (n_ty >= n_dd) begin
                r_dry[k+1] <= RadW'(n_ty - n_dd);
                r_dqy[k+1] <= {r_dqy[k][RadW-2:0], 1'b1};
            end else begin
                r_dry[k+1] <= n_ty[RadW-1:0];
                r_dqy[k+1] <= {r_dqy[k][RadW-2:0], 1'b0};
            end
        end
    end

    // ---------------- output register ----------------
    t_meta  n_mo;
    logic   n_push_on;
    t_coord n_qx, n_qy;

    assign n_mo      = r_dm[Steps];
    assign n_push_on = n_mo.hit && (n_mo.d != '0);
    assign n_qx      = {1'b0, r_dqx[Steps]};
    assign n_qy      = {1'b0, r_dqy[Steps]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else          o_valid <= r_dv[Steps];
        o_hit    <= n_mo.hit;
        o_push_x <= !n_push_on ? '0 : (n_mo.sx ? -n_qx : n_qx);
        o_push_y <= !n_push_on ? '0 : (n_mo.sy ? -n_qy : n_qy);
        o_near_x <= n_mo.hit ? n_mo.nx : '0;
        o_near_y <= n_mo.hit ? n_mo.ny : '0;
    end

endmodule
